FILE: design/cebf_pkg.sv
// shared constants and types of the cross edge blend filter
`default_nettype none

package cebf_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	// fixed width of the size registers
	localparam int CFG_W = 11;
	localparam int IDX_W = 1;

	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	// column index, effective width, output row, input row / effective height
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WID_W = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

	localparam int LUMA_R     = 299;
	localparam int LUMA_G     = 587;
	localparam int LUMA_B     = 114;
	localparam int LUMA_PEAK  = (LUMA_R + LUMA_G + LUMA_B) * 255;
	localparam int LUMA_W     = $clog2(LUMA_PEAK + 1);
	localparam int EDGE_SCALE = 10;
	localparam int RANGE_W    = $clog2(EDGE_SCALE * LUMA_PEAK + 1);

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pix_t;

	// word leaving the control stage; every valid one is pushed into the line store
	typedef struct packed {
		logic emit;
		logic interior;
		logic last;
		pix_t pix;
	} item_t;

	// cross window without the row above, which arrives from the second line memory
	typedef struct packed {
		logic interior;
		logic last;
		pix_t ct;
		pix_t lf;
		pix_t rt;
		pix_t dn;
	} win_t;

endpackage

`default_nettype wire

FILE: design/cebf_ram.sv
// generic single-port ram with registered read, old data on a same-address write
`default_nettype none

module cebf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rdata_q <= mem_q[addr];
			if (we) begin
				mem_q[addr] <= wdata;
			end
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: design/cebf_ctrl.sv
// size registers, frame position counters and the first pipeline stage
`default_nettype none

module cebf_ctrl
	import cebf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              cfg_we,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	input  wire logic              fire,
	input  wire logic              req_type,
	input  wire pix_t              pix,
	output logic                   valid_s1,
	output item_t                  item_s1,
	output logic [WID_W-1:0]       frame_w,
	output logic                   restart
);

	logic [WID_W-1:0] width_q;
	logic [HGT_W-1:0] height_q;
	logic [COL_W-1:0] in_col_q;
	logic [HGT_W-1:0] in_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;

	logic cfg_hit;
	logic is_pix;
	logic take_pix;
	logic take_flush;
	logic push;
	logic emit;
	logic col_end;
	logic small_frame;
	logic ocol_last;
	logic orow_last;
	logic interior;
	logic last;

	function automatic logic [WID_W-1:0] sat_width(logic [CFG_W-1:0] v);
		if (v == '0) return WID_W'(1);
		if (int'(v) > MAX_WIDTH) return WID_W'(MAX_WIDTH);
		return WID_W'(v);
	endfunction

	function automatic logic [HGT_W-1:0] sat_height(logic [CFG_W-1:0] v);
		if (v == '0) return HGT_W'(1);
		if (int'(v) > MAX_HEIGHT) return HGT_W'(MAX_HEIGHT);
		return HGT_W'(v);
	endfunction

	always_comb begin
		cfg_hit     = cfg_we && (cfg_index inside {REG_FRAME_WIDTH, REG_FRAME_HEIGHT});
		is_pix      = req_type == REQ_PIXEL;
		take_pix    = is_pix && (in_row_q < height_q);
		take_flush  = !is_pix && (in_row_q >= height_q);
		push        = take_pix || take_flush;
		emit        = (take_pix && in_row_q != '0) || take_flush;
		col_end     = WID_W'(in_col_q) == width_q - 1'b1;
		small_frame = (width_q < WID_W'(3)) || (height_q < HGT_W'(3));
		ocol_last   = WID_W'(out_col_q) == width_q - 1'b1;
		orow_last   = HGT_W'(out_row_q) == height_q - 1'b1;
		interior    = !small_frame && out_row_q != '0 && !orow_last &&
			out_col_q != '0 && !ocol_last;
		last        = orow_last && ocol_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WID_W'(MAX_WIDTH);
			height_q  <= HGT_W'(MAX_HEIGHT);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (cfg_hit) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  width_q  <= sat_width(cfg_data);
					REG_FRAME_HEIGHT: height_q <= sat_height(cfg_data);
					default: ;
				endcase
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else if (fire) begin
				if (take_pix) begin
					if (col_end) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + 1'b1;
					end else begin
						in_col_q <= in_col_q + 1'b1;
					end
				end
				if (emit) begin
					if (last) begin
						in_col_q  <= '0;
						in_row_q  <= '0;
						out_col_q <= '0;
						out_row_q <= '0;
					end else if (ocol_last) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 1'b1;
					end else begin
						out_col_q <= out_col_q + 1'b1;
					end
				end
			end
			if (en) begin
				valid_s1 <= fire && push;
			end
		end
	end

	// flush words push a black pixel
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1.emit     <= emit;
			item_s1.interior <= interior;
			item_s1.last     <= last;
			item_s1.pix      <= is_pix ? pix : '0;
		end
	end

	assign frame_w = width_q;
	assign restart = cfg_hit;

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_row_q <= height_q)
		else $error("input row beyond frame height");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		WID_W'(out_col_q) < width_q && HGT_W'(out_row_q) < height_q)
		else $error("output position outside frame");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> (in_row_q == '0 && in_col_q == '0 && out_col_q == '0 && out_row_q == '0))
		else $error("size write did not restart the frame");

endmodule

`default_nettype wire

FILE: design/cebf_window.sv
// two row delays in ram and the column taps that build the cross window
`default_nettype none

module cebf_window
	import cebf_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             restart,
	input  wire logic [WID_W-1:0] frame_w,
	input  wire logic             valid_s1,
	input  wire item_t            item_s1,
	output logic                  valid_s3,
	output win_t                  win_s3,
	output pix_t                  up_s3
);

	logic [COL_W-1:0] ptr1_q;
	logic [COL_W-1:0] ptr2_q;
	logic             valid_s2;
	item_t            item_s2;
	pix_t             ctr_q;
	pix_t             lft_q;
	pix_t             rd1;
	pix_t             rd2;
	pix_t             right;
	logic             acc1;
	logic             acc2;

	assign acc1 = en && valid_s1;
	assign acc2 = en && valid_s2;

	// first delay is width-1 words long, the center tap adds one more
	cebf_ram #(
		.WIDTH($bits(pix_t)),
		.DEPTH(MAX_WIDTH)
	) u_ram1 (
		.clk   (clk),
		.en    (acc1),
		.we    (1'b1),
		.addr  (ptr1_q),
		.wdata (item_s1.pix),
		.rdata (rd1)
	);

	// single-column frames have no delay ahead of the center tap
	assign right = (frame_w == WID_W'(1)) ? item_s2.pix : rd1;

	// second delay is a full row behind the center tap
	cebf_ram #(
		.WIDTH($bits(pix_t)),
		.DEPTH(MAX_WIDTH)
	) u_ram2 (
		.clk   (clk),
		.en    (acc2),
		.we    (1'b1),
		.addr  (ptr2_q),
		.wdata (ctr_q),
		.rdata (rd2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr1_q   <= '0;
			ptr2_q   <= '0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (restart) begin
				ptr1_q <= '0;
				ptr2_q <= '0;
			end else begin
				if (acc1) begin
					if (WID_W'(ptr1_q) == frame_w - WID_W'(2)) ptr1_q <= '0;
					else ptr1_q <= ptr1_q + 1'b1;
				end
				if (acc2) begin
					if (WID_W'(ptr2_q) == frame_w - 1'b1) ptr2_q <= '0;
					else ptr2_q <= ptr2_q + 1'b1;
				end
			end
			if (en) begin
				valid_s2 <= valid_s1;
				valid_s3 <= valid_s2 && item_s2.emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2         <= item_s1;
			win_s3.interior <= item_s2.interior;
			win_s3.last     <= item_s2.last;
			win_s3.ct       <= ctr_q;
			win_s3.lf       <= lft_q;
			win_s3.rt       <= right;
			win_s3.dn       <= item_s2.pix;
		end
		if (acc2) begin
			ctr_q <= right;
			lft_q <= ctr_q;
		end
	end

	assign up_s3 = rd2;

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		WID_W'(ptr2_q) < frame_w)
		else $error("row delay pointer beyond frame width");

endmodule

`default_nettype wire

FILE: design/cebf_blend.sv
// luma, contrast test, direction choice and blend, ending in the output register
`default_nettype none

module cebf_blend
	import cebf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_s3,
	input  wire win_t win_s3,
	input  wire pix_t up_s3,
	output logic      out_valid,
	output pix_t      out_pix,
	output logic      out_blended,
	output logic      out_last
);

	typedef struct packed {
		logic [LUMA_W-1:0] c;
		logic [LUMA_W-1:0] l;
		logic [LUMA_W-1:0] r;
		logic [LUMA_W-1:0] u;
		logic [LUMA_W-1:0] d;
	} lumas_t;

	function automatic logic [LUMA_W-1:0] luma(pix_t p);
		return LUMA_W'(LUMA_R * int'(p.r) + LUMA_G * int'(p.g) + LUMA_B * int'(p.b));
	endfunction

	function automatic logic [LUMA_W-1:0] lmax(logic [LUMA_W-1:0] a, logic [LUMA_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [LUMA_W-1:0] lmin(logic [LUMA_W-1:0] a, logic [LUMA_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [LUMA_W-1:0] adiff(logic [LUMA_W-1:0] a, logic [LUMA_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// (2c + a + b) >> 2 per channel
	function automatic pix_t avg(pix_t c, pix_t a, pix_t b);
		logic [9:0] sr;
		logic [9:0] sg;
		logic [9:0] sb;
		pix_t       res;
		sr = {1'b0, c.r, 1'b0} + 10'(a.r) + 10'(b.r);
		sg = {1'b0, c.g, 1'b0} + 10'(a.g) + 10'(b.g);
		sb = {1'b0, c.b, 1'b0} + 10'(a.b) + 10'(b.b);
		res.r = sr[9:2];
		res.g = sg[9:2];
		res.b = sb[9:2];
		return res;
	endfunction

	// s4: lumas
	logic   valid_s4;
	lumas_t lum_s4;
	win_t   win_s4;
	pix_t   up_s4;

	// s5: spread, gradients, both blend candidates
	logic              valid_s5;
	logic [LUMA_W-1:0] mx_s5;
	logic [LUMA_W-1:0] mn_s5;
	logic [LUMA_W-1:0] dh_s5;
	logic [LUMA_W-1:0] dv_s5;
	pix_t              vert_s5;
	pix_t              horz_s5;
	pix_t              ct_s5;
	logic              interior_s5;
	logic              last_s5;

	// s6: scaled spread and chosen candidate
	logic               valid_s6;
	logic [RANGE_W-1:0] range_s6;
	logic [LUMA_W-1:0]  mx_s6;
	pix_t               pick_s6;
	pix_t               ct_s6;
	logic               interior_s6;
	logic               last_s6;

	logic              valid_q;
	pix_t              pix_q;
	logic              blended_q;
	logic              last_q;

	logic [LUMA_W-1:0] mx_c;
	logic [LUMA_W-1:0] mn_c;
	logic              is_edge;

	always_comb begin
		mx_c = lmax(lmax(lmax(lum_s4.c, lum_s4.l), lmax(lum_s4.r, lum_s4.u)), lum_s4.d);
		mn_c = lmin(lmin(lmin(lum_s4.c, lum_s4.l), lmin(lum_s4.r, lum_s4.u)), lum_s4.d);
		is_edge = range_s6 >= RANGE_W'(mx_s6);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_q  <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lum_s4.c <= luma(win_s3.ct);
			lum_s4.l <= luma(win_s3.lf);
			lum_s4.r <= luma(win_s3.rt);
			lum_s4.u <= luma(up_s3);
			lum_s4.d <= luma(win_s3.dn);
			win_s4   <= win_s3;
			up_s4    <= up_s3;

			mx_s5       <= mx_c;
			mn_s5       <= mn_c;
			dh_s5       <= adiff(lum_s4.l, lum_s4.r);
			dv_s5       <= adiff(lum_s4.u, lum_s4.d);
			vert_s5     <= avg(win_s4.ct, up_s4, win_s4.dn);
			horz_s5     <= avg(win_s4.ct, win_s4.lf, win_s4.rt);
			ct_s5       <= win_s4.ct;
			interior_s5 <= win_s4.interior;
			last_s5     <= win_s4.last;

			range_s6    <= RANGE_W'(int'(mx_s5 - mn_s5) * EDGE_SCALE);
			mx_s6       <= mx_s5;
			// a stronger horizontal gradient means a vertical edge: blend along the column
			pick_s6     <= (dh_s5 > dv_s5) ? vert_s5 : horz_s5;
			ct_s6       <= ct_s5;
			interior_s6 <= interior_s5;
			last_s6     <= last_s5;

			pix_q     <= (interior_s6 && is_edge) ? pick_s6 : ct_s6;
			blended_q <= interior_s6 && is_edge;
			last_q    <= last_s6;
		end
	end

	assign out_valid   = valid_q;
	assign out_pix     = pix_q;
	assign out_blended = blended_q;
	assign out_last    = last_q;

endmodule

`default_nettype wire

FILE: design/cross_edge_blend_filter.sv
// one word per cycle unless stalled; each pushed word does one access on each line memory
// results trail the input by one row, flush words after the frame drain the last row
// the whole pipeline holds while a result is waiting and out_stall is high
// reset clears counters, valid bits and sizes (1024 x 1024); line memories are not cleared
`default_nettype none

module cross_edge_blend_filter
	import cebf_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             req_type,
	input  wire logic [7:0]       in_red,
	input  wire logic [7:0]       in_green,
	input  wire logic [7:0]       in_blue,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [7:0]            out_red,
	output logic [7:0]            out_green,
	output logic [7:0]            out_blue,
	output logic                  blended,
	output logic                  frame_end
);

	logic             en;
	logic             fire;
	pix_t             in_pix;
	logic             valid_s1;
	item_t            item_s1;
	logic [WID_W-1:0] frame_w;
	logic             restart;
	logic             valid_s3;
	win_t             win_s3;
	pix_t             up_s3;
	pix_t             out_pix;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign fire     = in_valid && en;

	assign in_pix.r = in_red;
	assign in_pix.g = in_green;
	assign in_pix.b = in_blue;

	cebf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.req_type  (req_type),
		.pix       (in_pix),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.frame_w   (frame_w),
		.restart   (restart)
	);

	cebf_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.restart  (restart),
		.frame_w  (frame_w),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.valid_s3 (valid_s3),
		.win_s3   (win_s3),
		.up_s3    (up_s3)
	);

	cebf_blend u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.valid_s3    (valid_s3),
		.win_s3      (win_s3),
		.up_s3       (up_s3),
		.out_valid   (out_valid),
		.out_pix     (out_pix),
		.out_blended (blended),
		.out_last    (frame_end)
	);

	assign out_red   = out_pix.r;
	assign out_green = out_pix.g;
	assign out_blue  = out_pix.b;

endmodule

`default_nettype wire

FILE: bench/cross_edge_blend_filter_checker.sv
// checker for the cross edge blend filter: predicts filtered pixels and compares them
`default_nettype none

module cross_edge_blend_filter_checker
	import cebf_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             in_valid,
	input  wire logic             in_stall,
	input  wire logic             req_type,
	input  wire logic [7:0]       in_red,
	input  wire logic [7:0]       in_green,
	input  wire logic [7:0]       in_blue,
	input  wire logic             out_valid,
	input  wire logic             out_stall,
	input  wire logic [7:0]       out_red,
	input  wire logic [7:0]       out_green,
	input  wire logic [7:0]       out_blue,
	input  wire logic             blended,
	input  wire logic             frame_end,
	output int                    fail_count,
	output int                    pending,
	output int                    result_count,
	output int                    blend_count,
	output int                    frame_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH  = 2 * MAX_WIDTH + 1;
	localparam int REPORT_LIMIT = 60;

	typedef struct packed {
		pix_t pix;
		logic blend;
		logic last;
	} filtered_t;

	filtered_t        expected_pixels [$];
	pix_t             line_mem [STORE_DEPTH];
	int               wr_ptr;
	int               in_col;
	int               in_row;
	int               out_idx;
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;

	function automatic int clamp_size(logic [CFG_W-1:0] v, int hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return int'(v);
	endfunction

	function automatic int luma(pix_t p);
		return LUMA_R * p.r + LUMA_G * p.g + LUMA_B * p.b;
	endfunction

	function automatic int absdiff(int a, int b);
		return (a > b) ? a - b : b - a;
	endfunction

	// pixel written back words before the newest one
	function automatic pix_t recent(int back);
		return line_mem[(wr_ptr + STORE_DEPTH - back) % STORE_DEPTH];
	endfunction

	task automatic store_pix(pix_t p);
		wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
		line_mem[wr_ptr] = p;
	endtask

	// output pixel at out_idx; its center entered one row ago
	task automatic produce_pixel(int w, int h);
		int        orow, ocol;
		int        lc, ll, lr, lu, ld, mx, mn;
		pix_t      ct, up, dn, lf, rt, a, b;
		filtered_t res;
		orow = out_idx / w;
		ocol = out_idx % w;
		ct = recent(w);
		res.pix = ct;
		res.blend = 1'b0;
		if (w >= 3 && h >= 3 && orow >= 1 && orow + 1 < h && ocol >= 1 && ocol + 1 < w) begin
			up = recent(2 * w);
			dn = recent(0);
			lf = recent(w + 1);
			rt = recent(w - 1);
			lc = luma(ct);
			ll = luma(lf);
			lr = luma(rt);
			lu = luma(up);
			ld = luma(dn);
			mx = lc;
			mn = lc;
			if (ll > mx) mx = ll;
			if (lr > mx) mx = lr;
			if (lu > mx) mx = lu;
			if (ld > mx) mx = ld;
			if (ll < mn) mn = ll;
			if (lr < mn) mn = lr;
			if (lu < mn) mn = lu;
			if (ld < mn) mn = ld;
			if (EDGE_SCALE * (mx - mn) >= mx) begin
				// strong horizontal change blends along the column
				if (absdiff(ll, lr) > absdiff(lu, ld)) begin
					a = up;
					b = dn;
				end else begin
					a = lf;
					b = rt;
				end
				res.pix.r = 8'((2 * ct.r + a.r + b.r) >> 2);
				res.pix.g = 8'((2 * ct.g + a.g + b.g) >> 2);
				res.pix.b = 8'((2 * ct.b + a.b + b.b) >> 2);
				res.blend = 1'b1;
			end
		end
		res.last = (out_idx + 1 >= w * h);
		expected_pixels.push_back(res);
		if (res.last) begin
			in_col = 0;
			in_row = 0;
			out_idx = 0;
		end else begin
			out_idx++;
		end
	endtask

	task automatic take_word(logic kind, pix_t p);
		int   w, h;
		logic has_out;
		w = clamp_size(width_reg, MAX_WIDTH);
		h = clamp_size(height_reg, MAX_HEIGHT);
		if (kind == REQ_PIXEL) begin
			// pixels after the last row are dropped while the frame drains
			if (in_row >= h)
				return;
			store_pix(p);
			has_out = (in_row >= 1);
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
			if (has_out)
				produce_pixel(w, h);
		end else begin
			// flush before the frame is complete does nothing
			if (in_row < h)
				return;
			store_pix('0);
			produce_pixel(w, h);
		end
	endtask

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			if (fail_count < REPORT_LIMIT)
				$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_pixel();
		filtered_t want;
		if (expected_pixels.size() == 0) begin
			if (fail_count < REPORT_LIMIT)
				$error("filtered word with nothing expected: rgb %0d %0d %0d",
					out_red, out_green, out_blue);
			fail_count++;
			return;
		end
		want = expected_pixels.pop_front();
		result_count++;
		if (want.blend)
			blend_count++;
		if (want.last)
			frame_count++;
		check_field("out_red", want.pix.r, out_red);
		check_field("out_green", want.pix.g, out_green);
		check_field("out_blue", want.pix.b, out_blue);
		check_field("blended", 8'(want.blend), 8'(blended));
		check_field("frame_end", 8'(want.last), 8'(frame_end));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_pixels.delete();
			wr_ptr = 0;
			in_col = 0;
			in_row = 0;
			out_idx = 0;
			width_reg = CFG_W'(MAX_WIDTH);
			height_reg = CFG_W'(MAX_HEIGHT);
			fail_count = 0;
			pending = 0;
			result_count = 0;
			blend_count = 0;
			frame_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  width_reg = cfg_data;
					REG_FRAME_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
				// any register write restarts the frame
				in_col = 0;
				in_row = 0;
				out_idx = 0;
			end
			if (in_valid && !in_stall)
				take_word(req_type, {in_red, in_green, in_blue});
			if (out_valid && !out_stall)
				check_pixel();
			pending = expected_pixels.size();
		end
	end

endmodule

`default_nettype wire

FILE: bench/cross_edge_blend_filter_tb.sv
// top of the cross edge blend filter bench: stimulus, pacing and verdict
`default_nettype none

module cross_edge_blend_filter_tb
	import cebf_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_WORDS  = 100;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             req_type = REQ_PIXEL;
	logic [7:0]       in_red = '0;
	logic [7:0]       in_green = '0;
	logic [7:0]       in_blue = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [7:0]       out_red;
	logic [7:0]       out_green;
	logic [7:0]       out_blue;
	logic             blended;
	logic             frame_end;

	int               fail_count;
	int               pending;
	int               result_count;
	int               blend_count;
	int               frame_count;

	int unsigned      cycle_count = 0;
	int               sent_words = 0;
	int               useful_words = 0;
	int               setting_count = 0;
	bit               quiet = 1'b0;
	pix_t             tone_a, tone_b;
	bit               split_rows;
	int               split;

	cross_edge_blend_filter dut (.*);

	cross_edge_blend_filter_checker chk (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("run stopped after %0d cycles with %0d words still expected",
			cycle_count, pending);
		$display("TB_ERROR");
		$finish;
	end

	// result side: random stall before each word, none in quiet stretches
	initial begin : sink_pacing
		int hold;
		wait (arst_n);
		@(negedge clk);
		forever begin
			hold = quiet ? 0 : $urandom_range(0, 3);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	task automatic send_word(logic kind, pix_t p);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		in_red <= p.r;
		in_green <= p.g;
		in_blue <= p.b;
		do @(posedge clk); while (in_stall);
		sent_words++;
		@(negedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// drain everything and let the pipeline empty before touching the sizes
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic pix_t scene_pixel(int mode, int row, int col);
		pix_t p;
		logic far_side;
		case (mode)
			0: p = pix_t'($urandom);
			1: p = tone_a;
			default: begin
				far_side = split_rows ? (row >= split) : (col >= split);
				p = far_side ? tone_b : tone_a;
			end
		endcase
		if (mode != 0) begin
			p.r = p.r + 8'($urandom_range(0, 3));
			p.g = p.g + 8'($urandom_range(0, 3));
			p.b = p.b + 8'($urandom_range(0, 3));
		end
		return p;
	endfunction

	// one frame of w x h effective size; stops after 'stop' pixels if that cuts it short
	task automatic run_frame(int w, int h, int stop);
		int mode;
		mode = $urandom_range(0, 2);
		tone_a = pix_t'($urandom & 32'hFCFCFC);
		tone_b = pix_t'($urandom & 32'hFCFCFC);
		split_rows = 1'($urandom_range(0, 1));
		split = $urandom_range(0, split_rows ? h : w);
		for (int k = 0; k < stop && k < w * h; k++) begin
			// early flush, dropped by the block
			if ($urandom_range(0, 49) == 0)
				send_word(REQ_FLUSH, pix_t'($urandom));
			send_word(REQ_PIXEL, scene_pixel(mode, k / w, k % w));
			useful_words++;
		end
		if (stop < w * h)
			return;
		// stray pixel while the last row drains
		if ($urandom_range(0, 3) == 0)
			send_word(REQ_PIXEL, pix_t'($urandom));
		repeat (w) begin
			send_word(REQ_FLUSH, pix_t'($urandom));
			useful_words++;
		end
		if ($urandom_range(0, 5) == 0)
			send_word(REQ_FLUSH, pix_t'($urandom));
	endtask

	initial begin : stimulus
		pix_t pattern [9];
		int   w, h, frames, start_words;
		pattern = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'hFF0000, 24'hFFFFFF,
			24'h00FF00, 24'h808080, 24'h00FFFF, 24'hFF00FF};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// smallest frame with one interior pixel, plus dropped flush and pixel
		write_reg(REG_FRAME_WIDTH, 11'd3);
		write_reg(REG_FRAME_HEIGHT, 11'd3);
		setting_count++;
		send_word(REQ_FLUSH, 24'hFFFFFF);
		foreach (pattern[i])
			send_word(REQ_PIXEL, pattern[i]);
		send_word(REQ_PIXEL, 24'h123456);
		repeat (3) send_word(REQ_FLUSH, 24'h000000);
		settle();

		// zero width saturates to one column
		write_reg(REG_FRAME_WIDTH, 11'd0);
		write_reg(REG_FRAME_HEIGHT, 11'd2);
		setting_count++;
		send_word(REQ_PIXEL, 24'hFF00FF);
		send_word(REQ_PIXEL, 24'h00FF00);
		send_word(REQ_FLUSH, 24'h5A5A5A);
		settle();

		// zero height saturates to one row
		write_reg(REG_FRAME_WIDTH, 11'd2);
		write_reg(REG_FRAME_HEIGHT, 11'd0);
		setting_count++;
		send_word(REQ_PIXEL, 24'hA5A5A5);
		send_word(REQ_PIXEL, 24'hFFFFFF);
		repeat (2) send_word(REQ_FLUSH, 24'hFFFFFF);
		settle();

		// oversized registers saturate to the largest frame; cut after the second row starts
		write_reg(REG_FRAME_WIDTH, 11'h7FF);
		write_reg(REG_FRAME_HEIGHT, 11'h7FF);
		setting_count++;
		run_frame(MAX_WIDTH, MAX_HEIGHT, MAX_WIDTH + 8);
		settle();

		start_words = useful_words;
		h = 3;
		write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
		while (useful_words - start_words < RANDOM_WORDS) begin
			quiet = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 4))
				0:       w = $urandom_range(1, 2);
				1:       w = $urandom_range(11, 40);
				default: w = $urandom_range(3, 10);
			endcase
			write_reg(REG_FRAME_WIDTH, (w == 1 && $urandom_range(0, 1) == 1) ? 11'd0 : CFG_W'(w));
			if ($urandom_range(0, 3) != 0) begin
				h = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
				write_reg(REG_FRAME_HEIGHT,
					(h == 1 && $urandom_range(0, 1) == 1) ? 11'd0 : CFG_W'(h));
			end
			setting_count++;
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				// last frame of a setting is sometimes abandoned partway
				if (f == frames - 1 && $urandom_range(0, 4) == 0)
					run_frame(w, h, $urandom_range(0, w * h - 1));
				else
					run_frame(w, h, w * h);
			end
			settle();
		end

		quiet = 1'b0;
		settle();
		$display("covered %0d input words over %0d size settings, %0d pixels checked",
			sent_words, setting_count, result_count);
		$display("%0d pixels blended, %0d frames completed", blend_count, frame_count);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
design/cebf_pkg.sv
design/cebf_ram.sv
design/cebf_ctrl.sv
design/cebf_window.sv
design/cebf_blend.sv
design/cross_edge_blend_filter.sv
bench/cross_edge_blend_filter_checker.sv
bench/cross_edge_blend_filter_tb.sv
